### sv/bcn_block_decoder_assert.svh
// Assertion macros shared by the block decoder modules.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef BCN_BLOCK_DECODER_ASSERT_SVH
`define BCN_BLOCK_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BCN_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`define BCN_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define BCN_ASSERT_IMP(label, ante, cons)
`define BCN_ASSERT_NXT(label, ante, cons)
`endif

`endif

### sv/bcn_pkg.sv
// Types and constants for the BC1..BC5 block decoder.
// No dependencies; used by every module of the block.
package bcn_pkg;

    typedef enum logic [2:0] {
        FMT_BC1 = 3'd0,
        FMT_BC2 = 3'd1,
        FMT_BC3 = 3'd2,
        FMT_BC4 = 3'd3,
        FMT_BC5 = 3'd4
    } t_format;

    // register index taken from paddr[2]
    localparam logic REG_BLOCK_FORMAT = 1'b0;

    typedef logic [3:0][31:0] t_cpal;
    typedef logic [7:0][7:0]  t_vpal;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
    } t_block_in;

    typedef struct packed {
        logic [1:0]  row_index;
        logic [31:0] texel_a;
        logic [31:0] texel_b;
        logic [31:0] texel_c;
        logic [31:0] texel_d;
        logic        final_row;
    } t_row_out;

    // one classified block, palettes resolved, waiting for row expansion
    typedef struct packed {
        logic [2:0]  format;
        t_cpal       cpal;
        t_vpal       vlo;
        t_vpal       vhi;
        logic [63:0] block_low;
        logic [63:0] block_high;
    } t_decoded;

endpackage

### sv/bcn_front.sv
// Front end: accepts a block, builds the colour and value palettes.
// Depends on bcn_pkg; feeds bcn_queue.
module bcn_front import bcn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_format,
    input  logic       i_push,
    input  t_block_in  i_block,
    output logic       o_full,
    output logic       o_q_push,
    output t_decoded   o_q_entry,
    input  logic       i_q_full
);

    // x/3, x/7, x/5 by reciprocal multiply; exact over the ranges used here
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd2341;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd1639;
        return p[20:13];
    endfunction

    function automatic t_vpal value_palette(input logic [7:0] a0, input logic [7:0] a1);
        t_vpal       pal;
        logic [10:0] s;
        pal    = '0;
        pal[0] = a0;
        pal[1] = a1;
        for (int i = 1; i <= 6; i++) begin
            if (a0 > a1) begin
                s = 11'(7 - i) * 11'(a0) + 11'(i) * 11'(a1);
                pal[i + 1] = div7(s);
            end else if (i <= 4) begin
                s = 11'(5 - i) * 11'(a0) + 11'(i) * 11'(a1);
                pal[i + 1] = div5(s);
            end
        end
        if (!(a0 > a1)) begin
            pal[6] = 8'h00;
            pal[7] = 8'hFF;
        end
        return pal;
    endfunction

    logic [63:0]      half;
    logic [15:0]      c0;
    logic [15:0]      c1;
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic [2:0][7:0]  m2;
    logic [2:0][7:0]  m3;
    logic [2:0][8:0]  avg_sum;
    logic             four_colour;
    t_cpal            cpal;
    logic             accept;

    logic             r_valid;
    logic             n_valid;
    t_decoded         r_entry;

    always_comb begin
        half = (i_format == FMT_BC1) ? i_block.block_low : i_block.block_high;
        c0   = half[15:0];
        c1   = half[31:16];
        e0[0] = {c0[15:11], c0[15:13]};
        e0[1] = {c0[10:5],  c0[10:9]};
        e0[2] = {c0[4:0],   c0[4:2]};
        e1[0] = {c1[15:11], c1[15:13]};
        e1[1] = {c1[10:5],  c1[10:9]};
        e1[2] = {c1[4:0],   c1[4:2]};
        for (int ch = 0; ch < 3; ch++) begin
            m2[ch]      = div3(10'({e0[ch], 1'b0}) + 10'(e1[ch]));
            m3[ch]      = div3(10'(e0[ch]) + 10'({e1[ch], 1'b0}));
            avg_sum[ch] = 9'(e0[ch]) + 9'(e1[ch]);
        end
        four_colour = (i_format != FMT_BC1) || (c0 > c1);
        cpal[0] = {8'hFF, e0[2], e0[1], e0[0]};
        cpal[1] = {8'hFF, e1[2], e1[1], e1[0]};
        if (four_colour) begin
            cpal[2] = {8'hFF, m2[2], m2[1], m2[0]};
            cpal[3] = {8'hFF, m3[2], m3[1], m3[0]};
        end else begin
            cpal[2] = {8'hFF, avg_sum[2][8:1], avg_sum[1][8:1], avg_sum[0][8:1]};
            cpal[3] = 32'h0000_0000;
        end
    end

    assign o_full    = r_valid && i_q_full;
    assign accept    = i_push && !o_full;
    assign o_q_push  = r_valid;
    assign o_q_entry = r_entry;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_q_full) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry.format     <= i_format;
            r_entry.cpal       <= cpal;
            r_entry.vlo        <= value_palette(i_block.block_low[7:0],
                                                i_block.block_low[15:8]);
            r_entry.vhi        <= value_palette(i_block.block_high[7:0],
                                                i_block.block_high[15:8]);
            r_entry.block_low  <= i_block.block_low;
            r_entry.block_high <= i_block.block_high;
        end
    end

endmodule

### sv/bcn_queue.sv
// Short queue of decoded blocks between the front and back ends.
// Depends on bcn_pkg and bcn_block_decoder_assert.svh.
`include "bcn_block_decoder_assert.svh"

module bcn_queue import bcn_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_decoded i_entry,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_decoded o_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_decoded           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_head;
    logic [PTR_W-1:0]   n_tail;
    logic [CNT_W-1:0]   n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_head];

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
        end
        if (do_pop) begin
            n_head = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_entry;
        end
    end

    `BCN_ASSERT_IMP(a_count_range, 1'b1, r_count <= CNT_W'(DEPTH))
    `BCN_ASSERT_NXT(a_count_inc, do_push && !do_pop, r_count == $past(r_count) + 1'b1)

endmodule

### sv/bcn_back.sv
// Back end: makes four rows of the head block, one per cycle unless stalled.
// Depends on bcn_pkg and bcn_block_decoder_assert.svh.
`include "bcn_block_decoder_assert.svh"

module bcn_back import bcn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_decoded i_q_entry,
    output logic     o_q_pop,
    output logic     o_empty,
    input  logic     i_pop,
    output t_row_out o_row
);

    logic [1:0]        r_row;
    logic [1:0]        n_row;
    logic              r_out_valid;
    logic              n_out_valid;
    t_row_out          r_out;
    logic              load;

    logic [31:0]       cword;
    logic [47:0]       aword_lo;
    logic [47:0]       aword_hi;
    logic [3:0]        t;
    logic [1:0]        ci;
    logic [2:0]        li;
    logic [2:0]        hj;
    logic [3:0]        a4;
    logic [31:0]       col;
    logic [3:0][31:0]  tex;

    always_comb begin
        cword    = (i_q_entry.format == FMT_BC1) ? i_q_entry.block_low[63:32]
                                                 : i_q_entry.block_high[63:32];
        aword_lo = i_q_entry.block_low[63:16];
        aword_hi = i_q_entry.block_high[63:16];
        t   = '0;
        ci  = '0;
        li  = '0;
        hj  = '0;
        a4  = '0;
        col = '0;
        for (int x = 0; x < 4; x++) begin
            t   = {r_row, 2'(x)};
            ci  = cword[{t, 1'b0} +: 2];
            li  = aword_lo[6'(t) * 6'd3 +: 3];
            hj  = aword_hi[6'(t) * 6'd3 +: 3];
            a4  = i_q_entry.block_low[{t, 2'b00} +: 4];
            col = i_q_entry.cpal[ci];
            case (i_q_entry.format)
                FMT_BC1: tex[x] = col;
                FMT_BC2: tex[x] = {a4, a4, col[23:0]};
                FMT_BC3: tex[x] = {i_q_entry.vlo[li], col[23:0]};
                FMT_BC4: tex[x] = {8'hFF, i_q_entry.vlo[li], i_q_entry.vlo[li],
                                   i_q_entry.vlo[li]};
                FMT_BC5: tex[x] = {8'hFF, 8'h00, i_q_entry.vhi[hj], i_q_entry.vlo[li]};
                default: tex[x] = 32'h0000_0000;
            endcase
        end
    end

    assign load    = i_q_valid && (!r_out_valid || i_pop);
    // the block leaves the queue once its last row is in the output register
    assign o_q_pop = load && (r_row == 2'd3);
    assign o_empty = !r_out_valid;
    assign o_row   = r_out;

    always_comb begin
        n_row       = r_row;
        n_out_valid = r_out_valid;
        if (load) begin
            n_row       = r_row + 2'd1;
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.row_index <= r_row;
            r_out.texel_a   <= tex[0];
            r_out.texel_b   <= tex[1];
            r_out.texel_c   <= tex[2];
            r_out.texel_d   <= tex[3];
            r_out.final_row <= (r_row == 2'd3);
        end
    end

    `BCN_ASSERT_IMP(a_final_row, r_out_valid, r_out.final_row == (r_out.row_index == 2'd3))
    `BCN_ASSERT_NXT(a_row_seq, r_out_valid && i_pop && !r_out.final_row,
                    r_out_valid && (r_out.row_index == $past(r_out.row_index) + 2'd1))

endmodule

### sv/bcn_block_decoder.sv
// Top level of the BC1..BC5 block decoder: config register, front, queue, back.
// Depends on bcn_pkg, bcn_front, bcn_queue and bcn_back.
//
// Usage:
//   Input queue port: a 16-byte compressed block on i_block is taken when push
//   is high and full is low. Result queue port: while empty is low, o_row holds
//   one texel row (four RGBA8 texels); pop takes it. Rows come out in order
//   0..3, final_row marks row 3.
//   block_format (BC1..BC5) sits at APB address 0; write it only while idle.
//   A block passes the front end's register and the queue before its first row
//   is registered onto o_row. Rows leave at one row per cycle while the
//   receiver pops, set by the back end's single row expansion unit. The front
//   end can take a new block every cycle until the QUEUE_DEPTH-entry queue and
//   its own stage are full.
//   Reset empties the queue and output register and sets block_format to BC1.
//   When the receiver stalls, the current row holds; the queue then fills and
//   full rises, after which the sender waits.
module bcn_block_decoder import bcn_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_block_in   i_block,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output t_row_out    o_row,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0] r_block_format;
    logic [2:0] n_block_format;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    t_decoded   q_in;
    t_decoded   q_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BLOCK_FORMAT) ? {29'd0, r_block_format} : 32'd0;

    always_comb begin
        n_block_format = r_block_format;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_BLOCK_FORMAT)) begin
            n_block_format = pwdata[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_format <= FMT_BC1;
        end else begin
            r_block_format <= n_block_format;
        end
    end

    bcn_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_format  (r_block_format),
        .i_push    (push),
        .i_block   (i_block),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_q_entry (q_in),
        .i_q_full  (q_full)
    );

    bcn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_out)
    );

    bcn_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!q_empty),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_row     (o_row)
    );

endmodule

### sim/tb.sv
// Self-checking bench for bcn_block_decoder: BC1..BC5 blocks are decoded here
// and each returned texel row is compared against the locally computed rows.
// Depends on bcn_pkg and the bcn_block_decoder RTL.
module tb;
    import bcn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT      = 300_000;
    localparam int          SETTLE_CYCLES    = 8;
    localparam int          ITEMS_PER_PHASE  = 82;
    localparam logic [2:0]  FMT_UNUSED_LO    = 3'd5;
    localparam logic [2:0]  FMT_UNUSED_HI    = 3'd7;

    // colour halves: c0 > c1, c0 < c1, c0 == c1 (all indices 3)
    localparam logic [63:0] CLR_FOUR  = 64'hE4E4E4E4_07E0F81F;
    localparam logic [63:0] CLR_THREE = 64'hE4E4E4E4_F81F07E0;
    localparam logic [63:0] CLR_EQUAL = 64'hFFFFFFFF_12341234;
    // value halves with index ramp 0..7: a0 > a1 (7-step), a0 < a1 (5-step + 0/255)
    localparam logic [63:0] LVL_DESC  = 64'hFAC688FAC688_10F0;
    localparam logic [63:0] LVL_ASC   = 64'hFAC688FAC688_F010;
    localparam logic [63:0] ALL_ONES  = 64'hFFFFFFFF_FFFFFFFF;

    typedef logic [3:0][31:0] t_colour_set;
    typedef logic [7:0][7:0]  t_level_set;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    t_block_in   i_block = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    t_row_out    o_row;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_row_out    expected_rows[$];
    t_row_out    row_want;
    logic [2:0]  format_reg = FMT_BC1;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          fail_count = 0;
    int unsigned cycle_count = 0;

    bcn_block_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_block (i_block),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_row   (o_row),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[bcn_block_decoder] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [23:0] expand565(input logic [15:0] c);
        return {c[4:0], c[4:2], c[10:5], c[10:9], c[15:11], c[15:13]};
    endfunction

    function automatic t_colour_set colour_set(input logic [63:0] half, input bit four);
        t_colour_set pal;
        logic [15:0] c0, c1;
        logic [23:0] e0, e1;
        logic [7:0]  p, q;
        c0 = half[15:0];
        c1 = half[31:16];
        e0 = expand565(c0);
        e1 = expand565(c1);
        pal = '0;
        pal[0] = {8'hFF, e0};
        pal[1] = {8'hFF, e1};
        pal[2][31:24] = 8'hFF;
        for (int k = 0; k < 3; k++) begin
            p = e0[8*k +: 8];
            q = e1[8*k +: 8];
            if (four || c0 > c1) begin
                pal[2][8*k +: 8] = 8'((2 * p + q) / 3);
                pal[3][8*k +: 8] = 8'((p + 2 * q) / 3);
            end else begin
                pal[2][8*k +: 8] = 8'((p + q) / 2);
            end
        end
        if (four || c0 > c1)
            pal[3][31:24] = 8'hFF;
        return pal;
    endfunction

    function automatic t_level_set level_set(input logic [63:0] half);
        t_level_set  pal;
        int unsigned a0, a1;
        a0 = {24'd0, half[7:0]};
        a1 = {24'd0, half[15:8]};
        pal[0] = a0[7:0];
        pal[1] = a1[7:0];
        if (a0 > a1) begin
            for (int unsigned i = 1; i <= 6; i++)
                pal[i+1] = 8'(((7 - i) * a0 + i * a1) / 7);
        end else begin
            for (int unsigned i = 1; i <= 4; i++)
                pal[i+1] = 8'(((5 - i) * a0 + i * a1) / 5);
            pal[6] = 8'd0;
            pal[7] = 8'd255;
        end
        return pal;
    endfunction

    function automatic void decode_block(input t_block_in blk, input logic [2:0] fmt);
        t_colour_set cpal;
        t_level_set  lv_lo, lv_hi;
        t_row_out    row;
        logic [63:0] lo, hi;
        logic [31:0] px;
        logic [7:0]  a, v;
        int          t;
        lo = blk.block_low;
        hi = blk.block_high;
        cpal = colour_set((fmt == FMT_BC1) ? lo : hi, fmt != FMT_BC1);
        lv_lo = level_set(lo);
        lv_hi = level_set(hi);
        for (int y = 0; y < 4; y++) begin
            row = '0;
            row.row_index = 2'(y);
            row.final_row = (y == 3);
            for (int x = 0; x < 4; x++) begin
                t = 4 * y + x;
                case (fmt)
                    FMT_BC1: px = cpal[lo[32 + 2*t +: 2]];
                    FMT_BC2: begin
                        a = 8'(lo[4*t +: 4] * 17);
                        px = {a, cpal[hi[32 + 2*t +: 2]][23:0]};
                    end
                    FMT_BC3: px = {lv_lo[lo[16 + 3*t +: 3]], cpal[hi[32 + 2*t +: 2]][23:0]};
                    FMT_BC4: begin
                        v = lv_lo[lo[16 + 3*t +: 3]];
                        px = {8'hFF, v, v, v};
                    end
                    FMT_BC5: px = {8'hFF, 8'h00, lv_hi[hi[16 + 3*t +: 3]],
                                   lv_lo[lo[16 + 3*t +: 3]]};
                    default: px = '0;
                endcase
                case (x)
                    0: row.texel_a = px;
                    1: row.texel_b = px;
                    2: row.texel_c = px;
                    default: row.texel_d = px;
                endcase
            end
            expected_rows.push_back(row);
        end
    endfunction

    // ---------------------------------------------------------------- checker

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %h got %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_rows.size() == 0) begin
                $error("row request with no row expected: %h", o_row);
                fail_count++;
            end else begin
                row_want = expected_rows.pop_front();
                check_field("row_index", 32'(row_want.row_index), 32'(o_row.row_index));
                check_field("texel_a",   row_want.texel_a,   o_row.texel_a);
                check_field("texel_b",   row_want.texel_b,   o_row.texel_b);
                check_field("texel_c",   row_want.texel_c,   o_row.texel_c);
                check_field("texel_d",   row_want.texel_d,   o_row.texel_d);
                check_field("final_row", 32'(row_want.final_row), 32'(o_row.final_row));
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_block(input t_block_in blk);
        while ($urandom_range(0, 99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_block <= blk;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        decode_block(blk, format_reg);
    endtask

    task automatic send_halves(input logic [63:0] lo, input logic [63:0] hi);
        t_block_in blk;
        blk.block_low = lo;
        blk.block_high = hi;
        send_block(blk);
    endtask

    // wait until every expected row is back, then let the pipeline go quiet
    task automatic settle_decoder();
        push <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_format(input logic [2:0] fmt);
        settle_decoder();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_BLOCK_FORMAT, 2'b00};
        pwdata <= {29'd0, fmt};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        format_reg = fmt;
        // read back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        check_field("block_format", {29'd0, fmt}, {29'd0, prdata[2:0]});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_block_in random_block();
        t_block_in blk;
        logic [15:0] ends;
        blk.block_low = {$urandom, $urandom};
        blk.block_high = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: begin
                blk.block_low[31:16] = blk.block_low[15:0];
                blk.block_high[31:16] = blk.block_high[15:0];
            end
            1: begin
                blk.block_low[15:8] = blk.block_low[7:0];
                blk.block_high[15:8] = blk.block_high[7:0];
            end
            2: begin
                ends = {16{$urandom_range(0, 1) == 1}};
                blk.block_low[31:0] = {~ends, ends};
                blk.block_high[31:0] = {ends, ~ends};
            end
            default: ;
        endcase
        return blk;
    endfunction

    // ---------------------------------------------------------------- tests

    // runs on the reset value of block_format first
    task automatic test_bc1_palettes();
        send_halves(64'd0, 64'd0);
        send_halves(ALL_ONES, ALL_ONES);
        send_halves(CLR_FOUR, ALL_ONES);
        load_format(FMT_BC1);
        send_halves(CLR_THREE, 64'd0);
        send_halves(CLR_EQUAL, 64'h0123456789ABCDEF);
    endtask

    task automatic test_bc2_bc3_alpha();
        load_format(FMT_BC2);
        send_halves(64'h0123456789ABCDEF, CLR_FOUR);
        // ascending endpoints still give four colours here
        send_halves(ALL_ONES, CLR_THREE);
        send_halves(64'd0, CLR_EQUAL);
        load_format(FMT_BC3);
        send_halves(LVL_DESC, CLR_THREE);
        send_halves(LVL_ASC, CLR_FOUR);
        send_halves(ALL_ONES, ALL_ONES);
    endtask

    task automatic test_bc4_bc5_channels();
        load_format(FMT_BC4);
        send_halves(LVL_DESC, ALL_ONES);
        send_halves(LVL_ASC, 64'd0);
        send_halves(64'd0, 64'd0);
        load_format(FMT_BC5);
        send_halves(LVL_DESC, LVL_ASC);
        send_halves(LVL_ASC, LVL_DESC);
        send_halves(ALL_ONES, 64'd0);
    endtask

    // codes past BC5 still return four rows of zero texels
    task automatic test_unused_formats();
        load_format(FMT_UNUSED_HI);
        send_halves(ALL_ONES, ALL_ONES);
        load_format(FMT_UNUSED_LO);
        send_halves(CLR_FOUR, LVL_DESC);
    endtask

    task automatic test_random_traffic(input int send_idle, input int recv_stall);
        int         sent;
        int         chunk;
        logic [2:0] fmt;
        sent = 0;
        idle_pct = send_idle;
        stall_pct = recv_stall;
        while (sent < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 9) == 0)
                fmt = 3'($urandom_range(FMT_UNUSED_LO, FMT_UNUSED_HI));
            else
                fmt = 3'($urandom_range(FMT_BC1, FMT_BC5));
            load_format(fmt);
            chunk = $urandom_range(8, 24);
            for (int i = 0; i < chunk; i++)
                send_block(random_block());
            sent += chunk;
        end
        settle_decoder();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bc1_palettes();
        test_bc2_bc3_alpha();
        test_bc4_bc5_channels();
        test_unused_formats();
        test_random_traffic(0, 0);
        test_random_traffic(64, 0);
        test_random_traffic(0, 64);
        test_random_traffic(22, 22);

        settle_decoder();
        if (fail_count == 0)
            $display("[bcn_block_decoder] OK");
        else
            $display("[bcn_block_decoder] ERROR");
        $finish;
    end

endmodule
